### sv/vmpbu_pkg.sv
package vmpbu_pkg;

   localparam int NUM_ANNOT   = 64;
   localparam int ANNOT_BITS  = $clog2(NUM_ANNOT);
   localparam int SCORE_BITS  = 32;
   localparam int SUM_BITS    = SCORE_BITS + 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
   localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};

   typedef enum logic [1:0] {
      KIND_LEX    = 2'd0,
      KIND_UNARY  = 2'd1,
      KIND_BINARY = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]                   req_type;
      logic [5:0]                   parent_annot;
      logic [5:0]                   left_annot;
      logic [5:0]                   right_annot;
      logic signed [SCORE_BITS-1:0] rule_score;
      logic signed [SCORE_BITS-1:0] left_score;
      logic signed [SCORE_BITS-1:0] right_score;
      logic                         parent_valid;
      logic                         left_valid;
      logic                         right_valid;
      logic [15:0]                  daughter_id;
   } req_item_type;

   typedef struct packed {
      logic [5:0]                   out_annot;
      logic signed [SCORE_BITS-1:0] best_score;
      logic [15:0]                  best_daughter;
      logic [5:0]                   best_left;
      logic [5:0]                   best_right;
      logic                         was_updated;
   } rsp_item_type;

   typedef struct packed {
      kind_type                     kind;
      logic [ANNOT_BITS-1:0]        parent;
      logic [5:0]                   left;
      logic [5:0]                   right;
      logic                         ok;
      logic signed [SCORE_BITS-1:0] cand;
      logic [15:0]                  daughter;
   } job_type;

   typedef struct packed {
      logic signed [SCORE_BITS-1:0] score;
      logic [15:0]                  daughter;
      logic [5:0]                   left;
      logic [5:0]                   right;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{score: SCORE_MIN, daughter: '0, left: '0, right: '0};

endpackage

### sv/vmpbu_front.sv
module vmpbu_front
   import vmpbu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output job_type      job,
   output logic         job_valid,
   input  logic         job_ready
);

   logic         stage_valid_ff, stage_valid_in;
   job_type      stage_ff, stage_in;
   logic         accept;
   kind_type     kind;
   logic signed [SUM_BITS-1:0] sum;
   logic         fits;

   assign busy   = stage_valid_ff && !job_ready;
   assign accept = start && !busy;

   always_comb begin
      kind = kind_type'(req_item.req_type);
      sum  = SUM_BITS'(req_item.rule_score);
      if (kind == KIND_UNARY || kind == KIND_BINARY) begin
         sum = sum + SUM_BITS'(req_item.left_score);
      end
      if (kind == KIND_BINARY) begin
         sum = sum + SUM_BITS'(req_item.right_score);
      end
      fits = (sum[SUM_BITS-1:SCORE_BITS-1] == '0) || (sum[SUM_BITS-1:SCORE_BITS-1] == '1);

      stage_in.kind     = kind;
      stage_in.parent   = req_item.parent_annot[ANNOT_BITS-1:0];
      stage_in.left     = req_item.left_annot;
      stage_in.right    = req_item.right_annot;
      stage_in.daughter = req_item.daughter_id;
      stage_in.ok       = req_item.parent_valid
                          && (kind == KIND_LEX || req_item.left_valid)
                          && (kind != KIND_BINARY || req_item.right_valid);
      if (fits) begin
         stage_in.cand = sum[SCORE_BITS-1:0];
      end else if (sum[SUM_BITS-1]) begin
         stage_in.cand = SCORE_MIN;
      end else begin
         stage_in.cand = SCORE_MAX;
      end
   end

   assign stage_valid_in = accept || (stage_valid_ff && !job_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign job       = stage_ff;
   assign job_valid = stage_valid_ff;

endmodule

### sv/vmpbu_queue.sv
module vmpbu_queue
   import vmpbu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop,
   output job_type pop_job
);

   job_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_job    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### sv/vmpbu_back.sv
module vmpbu_back
   import vmpbu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   output logic         job_pop,
   input  job_type      job,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type    state_ff, state_in;
   entry_type    entry_mem [NUM_ANNOT];
   logic [NUM_ANNOT-1:0] valid_ff;
   entry_type    rd_ff;
   logic         rd_valid_ff;
   job_type      cur_ff;
   logic         rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   entry_type    old_entry, new_entry;
   logic         upd;
   logic         wr_en;

   assign job_pop = (state_ff == ST_IDLE) && job_valid;

   always_comb begin
      old_entry = rd_valid_ff ? rd_ff : ENTRY_RESET;
      new_entry = old_entry;
      upd       = 1'b0;
      if (cur_ff.kind == KIND_CLEAR) begin
         new_entry = ENTRY_RESET;
         upd       = 1'b1;
      end else if (cur_ff.ok && (cur_ff.cand > old_entry.score)) begin
         new_entry.score    = cur_ff.cand;
         new_entry.daughter = cur_ff.daughter;
         if (cur_ff.kind != KIND_LEX) begin
            new_entry.left = cur_ff.left;
         end
         if (cur_ff.kind == KIND_BINARY) begin
            new_entry.right = cur_ff.right;
         end
         upd = 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      wr_en         = 1'b0;
      rsp_strobe_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            wr_en         = upd;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_item_in.out_annot     = 6'(cur_ff.parent);
      rsp_item_in.best_score    = new_entry.score;
      rsp_item_in.best_daughter = new_entry.daughter;
      rsp_item_in.best_left     = new_entry.left;
      rsp_item_in.best_right    = new_entry.right;
      rsp_item_in.was_updated   = upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (wr_en) begin
            valid_ff[cur_ff.parent] <= 1'b1;
         end
      end
   end

   // entry memory: read on pop, write in the following cycle
   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_ff      <= job;
         rd_ff       <= entry_mem[job.parent];
         rd_valid_ff <= valid_ff[job.parent];
      end
      if (wr_en) begin
         entry_mem[cur_ff.parent] <= new_entry;
      end
      if (rsp_strobe_in) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

### sv/viterbi_max_plus_best_update_top.sv
// start to rsp_strobe: classify stage, queue, entry read, then entry write and strobe
// the back end takes a new item only after the read-then-write of the last one
// a 2-entry queue and a classify stage let up to 3 items be taken ahead of the back end
// reset: synchronous, active high; all entries read as most negative score with zero fields
// through per-entry valid bits, so no clearing pass is needed and start is taken at once
module viterbi_max_plus_best_update_top
   import vmpbu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   job_type front_job;
   logic    front_valid;
   logic    front_ready;
   job_type back_job;
   logic    back_valid;
   logic    back_pop;

   vmpbu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .job       (front_job),
      .job_valid (front_valid),
      .job_ready (front_ready)
   );

   vmpbu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_job   (front_job),
      .pop_valid  (back_valid),
      .pop        (back_pop),
      .pop_job    (back_job)
   );

   vmpbu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (back_valid),
      .job_pop    (back_pop),
      .job        (back_job),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
